/* rtl/swah_pkg.sv */
// ----------------------------------------------------------------------------
// swah_pkg
// Shared types, constants and fixed-point helpers for the swept wah filter.
// ----------------------------------------------------------------------------
package swah_pkg;

  // configuration register indexes
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_FREQ_LOW  = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_FREQ_HIGH = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_FREQ_STEP = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_DAMPING   = 3'd4;

  // reset values of the registers
  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [12:0] RST_FREQ_LOW  = 13'd500;
  localparam logic [12:0] RST_FREQ_HIGH = 13'd1500;
  localparam logic [15:0] RST_FREQ_STEP = 16'd655;
  localparam logic [14:0] RST_DAMPING   = 15'd16384;
  localparam logic [28:0] RST_CENTER    = 29'd32768000;  // 500 Hz in Q13.16

  // angle constants, unsigned Q2.30
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FREQ_SPAN   = 64'd8192;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL_DAMP,
    OP_HIGH,
    OP_MUL_HIGH,
    OP_BAND,
    OP_MUL_BAND,
    OP_LOW
  } swah_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAMP,
    ST_HIGH,
    ST_MULH,
    ST_BAND,
    ST_MULB,
    ST_LOW,
    ST_OUT
  } swah_state_t;

  typedef struct packed {
    swah_op_t op;
    logic     out_load;
  } swah_cmd_t;

  typedef struct packed {
    logic bypass;
  } swah_status_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // 2*sin(x) in unsigned Q2.14 from a Q2.30 angle, taylor series to x^11
  function automatic logic [15:0] twice_sine_q14(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[15:0];
  endfunction

endpackage

/* rtl/swah_if.sv */
// ----------------------------------------------------------------------------
// swah_if
// Valid/ready stream interfaces for the sample input and the result output.
// ----------------------------------------------------------------------------
interface svf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface svf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

/* rtl/swept_svf_wah_filter_top.sv */
// ----------------------------------------------------------------------------
// swept_svf_wah_filter_top
// Auto-wah: chamberlin state-variable band-pass with a triangle-swept centre.
// ----------------------------------------------------------------------------
// a filtered sample steps through damp, high, mulh, band, mulb, low and out,
//   a bypassed one goes from idle straight to out; a new sample is taken only in
//   idle; one shared 17x32 multiplier is used three times, each product registered
// the next input is taken while a finished result still waits on the output
// reset (rst, synchronous): registers to their defaults, centre at 500 Hz
//   sweeping up, filter state cleared; the coefficient table is constant
module swept_svf_wah_filter_top
  import swah_pkg::*;
#(
  parameter int SAMPLE_RATE      = 48000,
  parameter int COEF_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  svf_in_if.sink               din,
  svf_out_if.source            dout
);

  // command and status between sequencer and datapath
  swah_cmd_t    cmd;
  swah_status_t status;

  // sequencer: owns the handshakes and the output valid flag
  swah_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config registers, coefficient table, filter and sweep state
  swah_datapath #(
    .SAMPLE_RATE      (SAMPLE_RATE),
    .COEF_TABLE_DEPTH (COEF_TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (din.sample),
    .out_sample (dout.out_sample),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

/* rtl/swah_ctrl.sv */
// ----------------------------------------------------------------------------
// swah_ctrl
// Sequencer for one sample: capture, three multiply steps, output handoff.
// ----------------------------------------------------------------------------
module swah_ctrl
  import swah_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  swah_status_t status,
  output swah_cmd_t    cmd
);

  swah_state_t state;
  swah_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.bypass ? ST_OUT : ST_DAMP;
        end
      end
      ST_DAMP: state_next = ST_HIGH;
      ST_HIGH: state_next = ST_MULH;
      ST_MULH: state_next = ST_BAND;
      ST_BAND: state_next = ST_MULB;
      ST_MULB: state_next = ST_LOW;
      ST_LOW:  state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
        end
      end
      ST_DAMP: cmd.op = OP_MUL_DAMP;
      ST_HIGH: cmd.op = OP_HIGH;
      ST_MULH: cmd.op = OP_MUL_HIGH;
      ST_BAND: cmd.op = OP_BAND;
      ST_MULB: cmd.op = OP_MUL_BAND;
      ST_LOW:  cmd.op = OP_LOW;
      ST_OUT:  cmd.out_load = !out_valid || out_ready;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/swah_datapath.sv */
// ----------------------------------------------------------------------------
// swah_datapath
// Config registers, coefficient table, shared multiplier, filter and sweep state.
// ----------------------------------------------------------------------------
module swah_datapath
  import swah_pkg::*;
#(
  parameter int SAMPLE_RATE      = 48000,
  parameter int COEF_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic signed [15:0]   sample,
  output logic signed [15:0]   out_sample,
  input  swah_cmd_t            cmd,
  output swah_status_t         status
);

  localparam int IdxW = $clog2(COEF_TABLE_DEPTH);

  // config registers
  logic        enable;
  logic [12:0] freq_low;
  logic [12:0] freq_high;
  logic [15:0] freq_step;
  logic [14:0] damping;

  // filter and sweep state
  logic [28:0]        center_freq;
  logic               sweep_down;
  logic signed [31:0] band_state;
  logic signed [31:0] low_state;

  // per-sample working registers
  logic signed [15:0] x;
  logic signed [15:0] result;
  logic        [15:0] coef;
  logic signed [31:0] high;
  logic signed [48:0] prod;

  // coefficient table, one constant entry per frequency bin
  logic [15:0] coef_table [COEF_TABLE_DEPTH];

  for (genvar k = 0; k < COEF_TABLE_DEPTH; k++) begin : g_coef
    localparam longint unsigned ThetaRaw = (PI_Q30 * 64'(k) * FREQ_SPAN) /
        (64'(COEF_TABLE_DEPTH) * 64'(SAMPLE_RATE));
    localparam longint unsigned Theta =
        (ThetaRaw > HALF_PI_Q30) ? HALF_PI_Q30 : ThetaRaw;
    localparam logic [15:0] Entry = twice_sine_q14(Theta);
    assign coef_table[k] = Entry;
  end

  // table index from the whole-hertz part of the centre frequency
  localparam logic [13:0] DepthW = 14'(COEF_TABLE_DEPTH);
  localparam logic [13:0] MaxIdx = 14'(COEF_TABLE_DEPTH - 1);

  logic [26:0]     idx_prod;
  logic [13:0]     idx_full;
  logic [IdxW-1:0] idx;

  always_comb begin
    idx_prod = 27'(center_freq[28:16]) * 27'(DepthW);
    idx_full = idx_prod[26:13];
    if (idx_full > MaxIdx) begin
      idx_full = MaxIdx;
    end
    idx = idx_full[IdxW-1:0];
  end

  // shared multiplier operands
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] prod_sh;

  always_comb begin
    if (cmd.op == OP_MUL_DAMP) begin
      mul_a = signed'({2'b00, damping});
    end else begin
      mul_a = signed'({1'b0, coef});
    end
    if (cmd.op == OP_MUL_HIGH) begin
      mul_b = high;
    end else begin
      mul_b = band_state;
    end
    prod_sh = prod >>> 14;
  end

  // sweep update, high limit first and low limit last
  logic signed [30:0] cf_ext;
  logic signed [30:0] step_ext;
  logic signed [30:0] hi_lim;
  logic signed [30:0] lo_lim;
  logic signed [30:0] cf_new;
  logic               dir_new;

  always_comb begin
    cf_ext   = signed'({2'b00, center_freq});
    step_ext = signed'({15'b0, freq_step});
    hi_lim   = signed'({2'b00, freq_high, 16'b0});
    lo_lim   = signed'({2'b00, freq_low, 16'b0});
    dir_new  = sweep_down;
    cf_new   = sweep_down ? (cf_ext - step_ext) : (cf_ext + step_ext);
    if (cf_new > hi_lim) begin
      cf_new  = hi_lim;
      dir_new = !dir_new;
    end
    if (cf_new < lo_lim) begin
      cf_new  = lo_lim;
      dir_new = !dir_new;
    end
  end

  assign status.bypass = !enable;

  // config and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= RST_ENABLE;
      freq_low    <= RST_FREQ_LOW;
      freq_high   <= RST_FREQ_HIGH;
      freq_step   <= RST_FREQ_STEP;
      damping     <= RST_DAMPING;
      center_freq <= RST_CENTER;
      sweep_down  <= 1'b0;
      band_state  <= '0;
      low_state   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:    enable    <= cfg_data[0];
          CFG_FREQ_LOW:  freq_low  <= cfg_data[12:0];
          CFG_FREQ_HIGH: freq_high <= cfg_data[12:0];
          CFG_FREQ_STEP: freq_step <= cfg_data[15:0];
          CFG_DAMPING:   damping   <= cfg_data[14:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_BAND: band_state <= sat32(40'(band_state) + 40'(prod_sh));
        OP_LOW: begin
          low_state   <= sat32(40'(low_state) + 40'(prod_sh));
          center_freq <= cf_new[28:0];
          sweep_down  <= dir_new;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        x      <= sample;
        result <= sample;
      end
      OP_MUL_DAMP: begin
        coef <= coef_table[idx];
        prod <= mul_a * mul_b;
      end
      OP_HIGH:     high <= sat32(40'(x) - 40'(low_state) - 40'(prod_sh));
      OP_MUL_HIGH: prod <= mul_a * mul_b;
      OP_MUL_BAND: prod <= mul_a * mul_b;
      OP_LOW:      result <= sat16(band_state);
      default: ;
    endcase
    if (cmd.out_load) begin
      out_sample <= result;
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swept state-variable wah filter. A directed
// table covers bypass, register extremes, crossed sweep limits and ignored
// register indexes, then random phases run the filter under every idling
// pattern. Every output transaction is checked against an in-bench model of
// the filter, its coefficient table and the triangle sweep of the centre.
// ----------------------------------------------------------------------------
module tb_top
  import swah_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int FS_HZ      = 48000;
  localparam int COEF_DEPTH = 256;

  // angle of pi in unsigned q2.30, and the frequency span the table covers
  localparam u64_t ANGLE_PI      = 64'd3373259426;
  localparam u64_t ANGLE_HALF_PI = 64'd1686629713;
  localparam u64_t SPAN_HZ       = 64'd8192;

  // indexes past the register list, written to prove they are ignored
  localparam logic [CfgIndexW-1:0] CFG_SPARE      = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_LAST_SPARE = 3'd7;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 20;
  localparam int QUIET_LIMIT     = 4000;
  localparam int REPORT_LIMIT    = 10;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CfgIndexW-1:0]  idx;     // register index, write rows only
    logic [15:0]           value;   // register data or input sample
    logic                  known;   // result typed in below
    logic [15:0]           result;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 33;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // straight out of reset: zero state, so silence stays silence
    '{ROW_SAMPLE, CFG_SPARE,      16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h1234, 1'b0, 16'h0000},
    // bypass: samples come back untouched
    '{ROW_WRITE,  CFG_ENABLE,     16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, CFG_SPARE,      16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h0001, 1'b1, 16'h0001},
    '{ROW_SAMPLE, CFG_SPARE,      16'hffff, 1'b1, 16'hffff},
    '{ROW_SAMPLE, CFG_SPARE,      16'haaaa, 1'b1, 16'haaaa},
    '{ROW_SAMPLE, CFG_SPARE,      16'h5555, 1'b1, 16'h5555},
    // write past the register list, still in bypass afterwards
    '{ROW_WRITE,  CFG_SPARE,      16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h0f0f, 1'b1, 16'h0f0f},
    // undamped, widest sweep, fastest step
    '{ROW_WRITE,  CFG_ENABLE,     16'h0001, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_DAMPING,    16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_FREQ_LOW,   16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_FREQ_HIGH,  16'h1fff, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_FREQ_STEP,  16'hffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h8000, 1'b0, 16'h0000},
    // heaviest damping
    '{ROW_WRITE,  CFG_DAMPING,    16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h8000, 1'b0, 16'h0000},
    // low limit above high limit: both clamps fire, low wins
    '{ROW_WRITE,  CFG_FREQ_LOW,   16'h0bb8, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_FREQ_HIGH,  16'h03e8, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h4000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'hc000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000},
    // frozen sweep
    '{ROW_WRITE,  CFG_FREQ_STEP,  16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_SPARE,      16'h7fff, 1'b0, 16'h0000}
  };

  // clock, reset and the block's plain inputs
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  // stream drive, routed into the interfaces below
  logic                 in_valid  = 1'b0;
  logic signed [15:0]   in_sample = '0;
  logic                 sink_ready = 1'b0;

  // idling percentages of the current phase
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // model copy of the registers
  logic        en_r;
  logic [12:0] flo_r;
  logic [12:0] fhi_r;
  logic [15:0] step_r;
  logic [14:0] damp_r;

  // model copy of the filter and sweep state
  longint      centre_q16;
  bit          sweeping_down;
  int          band_acc;
  int          low_acc;

  logic [15:0] coef_rom [COEF_DEPTH];

  logic signed [15:0] pending_wah_out [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  svf_in_if  in_ch ();
  svf_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.sample  = in_sample;
  assign out_ch.ready  = sink_ready;

  swept_svf_wah_filter_top #(
    .SAMPLE_RATE      (FS_HZ),
    .COEF_TABLE_DEPTH (COEF_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (in_ch),
    .dout      (out_ch)
  );

  always #6 clk = ~clk;

  // clamp to the signed 32-bit range of the filter accumulators
  function automatic longint clamp32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r;
  endfunction

  // one sample through the filter, then one sweep step of the centre; in bypass the sample passes and the sweep holds
  function automatic logic signed [15:0] wah_filter_step(input logic signed [15:0] x);
    longint slot;
    longint coef;
    longint hp;
    longint bp;
    longint lp;
    longint hi_lim;
    longint lo_lim;
    longint y;
    if (!en_r) begin
      return x;
    end
    slot = ((centre_q16 >>> 16) * COEF_DEPTH) >>> 13;
    if (slot >= COEF_DEPTH) begin
      slot = COEF_DEPTH - 1;
    end
    coef = longint'(coef_rom[slot]);

    // chamberlin update, each product floored by the arithmetic shift
    hp = clamp32(longint'(x) - longint'(low_acc)
                 - ((longint'(damp_r) * longint'(band_acc)) >>> 14));
    bp = clamp32(longint'(band_acc) + ((coef * hp) >>> 14));
    lp = clamp32(longint'(low_acc) + ((coef * bp) >>> 14));
    band_acc = int'(bp);
    low_acc  = int'(lp);

    y = bp;
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end

    // triangle sweep: high clamp first, low clamp has the last word
    hi_lim = longint'(fhi_r) << 16;
    lo_lim = longint'(flo_r) << 16;
    if (sweeping_down) begin
      centre_q16 = centre_q16 - longint'(step_r);
    end else begin
      centre_q16 = centre_q16 + longint'(step_r);
    end
    if (centre_q16 > hi_lim) begin
      centre_q16    = hi_lim;
      sweeping_down = !sweeping_down;
    end
    if (centre_q16 < lo_lim) begin
      centre_q16    = lo_lim;
      sweeping_down = !sweeping_down;
    end
    return 16'(y);
  endfunction

  // random register data: extremes now and then, junk above the field width
  function automatic logic [15:0] pick_field(input int unsigned w);
    int unsigned top;
    int unsigned v;
    top = (32'd1 << w) - 1;
    case ($urandom_range(9))
      0: v = 0;
      1: v = top;
      default: v = $urandom_range(0, top);
    endcase
    return 16'(($urandom << w) | v);
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENABLE:    en_r   = data[0];
      CFG_FREQ_LOW:  flo_r  = data[12:0];
      CFG_FREQ_HIGH: fhi_r  = data[12:0];
      CFG_FREQ_STEP: step_r = data[15:0];
      CFG_DAMPING:   damp_r = data[14:0];
      default: ;
    endcase
  endtask

  // offer one sample, hold it until the block takes it, then log the result
  task automatic send_sample(input logic signed [15:0] x, input logic known,
                             input logic signed [15:0] typed);
    logic signed [15:0] predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = wah_filter_step(x);
    pending_wah_out.push_back(known ? typed : predicted);
  endtask

  // drain everything in flight before touching a register
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wah_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver side, stalls drawn fresh every cycle
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // output checker
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && out_ch.valid && sink_ready) begin
      if (pending_wah_out.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("unexpected output transaction: got %0d", out_ch.out_sample);
        end
        mismatch_count++;
      end else begin
        want = pending_wah_out.pop_front();
        if (out_ch.out_sample !== want) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("out_sample mismatch: expected %0d, got %0d", want, out_ch.out_sample);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if (rst || (in_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] s;
    logic [15:0]        flo_data;
    u64_t               ang;
    u64_t               sq;
    u64_t               term;
    u64_t               den;
    longint             acc;

    // coefficient table: 2*sin of the bin angle, taylor series to x^11
    den = u64_t'(COEF_DEPTH) * u64_t'(FS_HZ);
    for (int k = 0; k < COEF_DEPTH; k++) begin
      ang = (ANGLE_PI * u64_t'(k) * SPAN_HZ) / den;
      if (ang > ANGLE_HALF_PI) begin
        ang = ANGLE_HALF_PI;
      end
      sq   = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 16384) >> 15;   // q30 to q14 of the doubled sine, half up
      if (acc > 32768) begin
        acc = 32768;
      end
      coef_rom[k] = acc[15:0];
    end

    // register defaults and state after reset
    en_r          = 1'b1;
    flo_r         = 13'd500;
    fhi_r         = 13'd1500;
    step_r        = 16'd655;
    damp_r        = 15'd16384;
    centre_q16    = longint'(500) << 16;
    sweeping_down = 1'b0;
    band_acc      = 0;
    low_acc       = 0;
    s             = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling on either side
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].value);
      end else begin
        send_sample(DIRECTED[r].value, DIRECTED[r].known, DIRECTED[r].result);
      end
    end

    // random phases, each with a fresh setting and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 34; snk_stall_pct = 34; end
      endcase

      case (ph)
        0: begin
          // top of every range, low limit at its bottom
          write_reg(CFG_ENABLE, 16'h0001);
          write_reg(CFG_FREQ_LOW, 16'h0000);
          write_reg(CFG_FREQ_HIGH, 16'h1fff);
          write_reg(CFG_FREQ_STEP, 16'hffff);
          write_reg(CFG_DAMPING, 16'h7fff);
        end
        1: begin
          // limits crossed as far as they go, no damping
          write_reg(CFG_ENABLE, 16'hffff);
          write_reg(CFG_FREQ_LOW, 16'h1fff);
          write_reg(CFG_FREQ_HIGH, 16'h0000);
          write_reg(CFG_FREQ_STEP, 16'hffff);
          write_reg(CFG_DAMPING, 16'h0000);
        end
        default: begin
          s = 16'($urandom);
          s[0] = (ph == 2) ? 1'b0 : ($urandom_range(99) < 85);
          write_reg(CFG_ENABLE, s);
          flo_data = pick_field(13);
          write_reg(CFG_FREQ_LOW, flo_data);
          // a narrow band keeps the sweep turning within one phase
          if ($urandom_range(1) == 1) begin
            write_reg(CFG_FREQ_HIGH, 16'({3'($urandom),
                      13'(flo_data[12:0] + 13'($urandom_range(0, 3)))}));
          end else begin
            write_reg(CFG_FREQ_HIGH, pick_field(13));
          end
          write_reg(CFG_FREQ_STEP, pick_field(16));
          write_reg(CFG_DAMPING, pick_field(15));
          if ($urandom_range(2) == 0) begin
            write_reg(3'($urandom_range(CFG_SPARE, CFG_LAST_SPARE)), 16'($urandom));
          end
        end
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0: s = 16'sh7fff;
          1: s = 16'sh8000;
          2, 3: s = 16'($urandom_range(0, 1023)) - 16'sd512;
          4: ;   // repeat the last sample, a held level drives the integrators
          default: s = 16'($urandom);
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    // drain and let the pipeline run dry
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_wah_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_wah_out.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swah_pkg.sv
rtl/swah_if.sv
rtl/swah_ctrl.sv
rtl/swah_datapath.sv
rtl/swept_svf_wah_filter_top.sv
tb/tb_top.sv
